>>> src/vertex_transform_defines.svh
// Assertion macros shared by the vertex transform design.
`ifndef VERTEX_TRANSFORM_DEFINES_SVH
`define VERTEX_TRANSFORM_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define VT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vt_pkg.sv
// Types, widths and constants for the vertex transform pipeline.
package vt_pkg;

    // Fixed-point format and widths.
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    // Three shifted products plus a translation entry fit without overflow.
    localparam int SUM_W     = 2 * COORD_W + 2 - FRAC_BITS;
    localparam int NUM_ROWS  = 4;
    localparam int NUM_COLS  = 4;
    localparam int NUM_AXES  = 3;

    // Configuration register file.
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 2 * COORD_W;
    localparam int CFG_IDX_W = 4;
    localparam int REG_SEL_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = CFG_IDX_W'(7);

    // Fixed-point one, placed on the diagonal at reset.
    localparam logic [COORD_W-1:0] FIX_ONE = COORD_W'(1) << FRAC_BITS;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [NUM_AXES-1:0]     point_t;
    typedef coord_t [NUM_ROWS-1:0]     result_t;
    typedef coord_t [NUM_COLS-1:0]     mat_row_t;
    typedef mat_row_t [NUM_ROWS-1:0]   matrix_t;

    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef prod_t [NUM_AXES-1:0]      prod_row_t;
    typedef prod_row_t [NUM_ROWS-1:0]  prod_arr_t;

    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef sum_t [NUM_ROWS-1:0]       sum_arr_t;

    // Identity matrix as register contents.
    function automatic logic [REG_W-1:0] reg_reset_value(input logic [REG_SEL_W-1:0] sel);
        logic [REG_W-1:0] val;
        begin
            val = '0;
            unique case (sel)
                REG_ROW0_COLS01[REG_SEL_W-1:0]: val = {{COORD_W{1'b0}}, FIX_ONE};
                REG_ROW1_COLS01[REG_SEL_W-1:0]: val = {FIX_ONE, {COORD_W{1'b0}}};
                REG_ROW2_COLS23[REG_SEL_W-1:0]: val = {{COORD_W{1'b0}}, FIX_ONE};
                REG_ROW3_COLS23[REG_SEL_W-1:0]: val = {FIX_ONE, {COORD_W{1'b0}}};
                default:                        val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

>>> src/vt_matrix.sv
// Configuration register file holding the 4x4 transform matrix.
module vt_matrix
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vt_pkg::REG_W-1:0]      cfg_data,
    output vt_pkg::matrix_t               matrix
);
    import vt_pkg::*;

    logic [REG_W-1:0] mat_reg [NUM_REGS];

    // Register writes; indexes past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mat_reg[i] <= reg_reset_value(REG_SEL_W'(i));
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            mat_reg[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
        end
    end

    // Each register carries two adjacent entries of one row.
    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < NUM_COLS; c++)
        begin : g_col
            assign matrix[r][c] = mat_reg[r * 2 + c / 2][(c % 2) * COORD_W +: COORD_W];
        end
    end

endmodule

>>> src/vt_mult.sv
// First pipeline stage: the twelve signed products of matrix and point.
module vt_mult
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vt_pkg::point_t      point,
    input  vt_pkg::matrix_t     matrix,
    output logic                out_valid,
    input  logic                out_ready,
    output vt_pkg::prod_arr_t   prod
);
    import vt_pkg::*;

    logic      valid_reg;
    prod_arr_t prod_reg;
    prod_arr_t prod_next;

    // The stage takes a new item whenever it is empty or draining.
    assign in_ready = !valid_reg || out_ready;

    // One 32 x 32 signed multiplier per matrix entry of the linear part.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                prod_next[r][c] = PROD_W'($signed(matrix[r][c])) * PROD_W'($signed(point[c]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

>>> src/vt_rowsum.sv
// Second pipeline stage: scale each product down and sum it along its row.
module vt_rowsum
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vt_pkg::prod_arr_t   prod,
    output logic                out_valid,
    input  logic                out_ready,
    output vt_pkg::sum_arr_t    sum
);
    import vt_pkg::*;

    logic     valid_reg;
    sum_arr_t sum_reg;
    sum_arr_t sum_next;

    assign in_ready = !valid_reg || out_ready;

    // The arithmetic shift rounds towards minus infinity; the result fits SUM_W.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            sum_next[r] = SUM_W'($signed(prod[r][0]) >>> FRAC_BITS)
                        + SUM_W'($signed(prod[r][1]) >>> FRAC_BITS)
                        + SUM_W'($signed(prod[r][2]) >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign sum       = sum_reg;

endmodule

>>> src/vt_saturate.sv
// Final pipeline stage: add the translation column, clamp to 32 bits, hold the result.
module vt_saturate
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vt_pkg::sum_arr_t    sum,
    input  vt_pkg::matrix_t     matrix,
    output logic                out_valid,
    input  logic                out_ready,
    output vt_pkg::result_t     result,
    output logic                clipped
);
    import vt_pkg::*;

    localparam sum_t SAT_MAX = {{(SUM_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam sum_t SAT_MIN = {{(SUM_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

    logic    valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    clipped_reg;
    logic    clipped_next;
    sum_t    total [NUM_ROWS];

    assign in_ready = !valid_reg || out_ready;

    // Clamp each row total and note whether any of them was clamped.
    always_comb
    begin
        clipped_next = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            total[r] = $signed(sum[r]) + SUM_W'($signed(matrix[r][NUM_COLS - 1]));
            if ($signed(total[r]) > SAT_MAX)
            begin
                result_next[r] = SAT_MAX[COORD_W-1:0];
                clipped_next   = 1'b1;
            end
            else if ($signed(total[r]) < SAT_MIN)
            begin
                result_next[r] = SAT_MIN[COORD_W-1:0];
                clipped_next   = 1'b1;
            end
            else
            begin
                result_next[r] = total[r][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg  <= result_next;
            clipped_reg <= clipped_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign clipped   = clipped_reg;

endmodule

>>> src/vertex_transform.sv
// Top level of the 4x4 homogeneous vertex transform pipeline.
//
// Points arrive on the slave stream (x, y, z in signed Q16.16) and each one
// leaves as one transfer on the master stream carrying homogeneous x, y, z
// and w, each clamped to the signed 32-bit range, with tuser set when any
// component was clamped. The matrix sits in eight 64-bit registers written
// through cfg_we, cfg_index and cfg_data; a write takes effect at once and
// indexes past the eighth register are ignored. Write the matrix only while
// no point is in flight.
//
// The pipeline has three register stages: multiply, shift and row sum, then
// translation add and clamp. An accepted point passes the multiply, row-sum
// and output registers in that order before it is offered on the master side.
// One point can enter every cycle while the receiver keeps up; the rate is
// set by the twelve parallel 32 x 32 multipliers in the first stage.
// When the receiver stalls, each stage holds its item and fills any empty
// stage ahead of it, so the pipeline packs up to three points before the
// slave side stops accepting. Reset empties the pipeline and loads the
// identity matrix.
`include "vertex_transform_defines.svh"

module vertex_transform
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,   // point_x, point_y, point_z
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [127:0]                  m_axis_tdata,   // out_x, out_y, out_z, out_w
    output logic [0:0]                    m_axis_tuser,   // clipped
    input  logic                          cfg_we,
    input  logic [vt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vt_pkg::REG_W-1:0]      cfg_data
);
    import vt_pkg::*;

    matrix_t   matrix;
    point_t    point;
    prod_arr_t prod;
    sum_arr_t  sum;
    result_t   result;
    logic      clipped;
    logic      mult_valid;
    logic      mult_ready;
    logic      sum_valid;
    logic      sum_ready;

    assign point = point_t'(s_axis_tdata);

    // Matrix registers.
    vt_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .matrix    (matrix)
    );

    // Stage one: products.
    vt_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .point     (point),
        .matrix    (matrix),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .prod      (prod)
    );

    // Stage two: shifted row sums.
    vt_rowsum u_rowsum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .prod      (prod),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .sum       (sum)
    );

    // Stage three: translation, clamp and output register.
    vt_saturate u_saturate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .sum       (sum),
        .matrix    (matrix),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result),
        .clipped   (clipped)
    );

    assign m_axis_tdata    = result;
    assign m_axis_tuser[0] = clipped;

    // An empty pipeline never refuses a point.
    `VT_ASSERT_NOW(a_empty_ready, !mult_valid && !sum_valid && !m_axis_tvalid,
        s_axis_tready, "empty pipeline refused an input transfer")

    // An accepted point occupies the first stage at the next edge.
    `VT_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready,
        mult_valid, "accepted point did not reach the multiply stage")

    // A row sum handed on must show on the output at the next edge.
    `VT_ASSERT_NEXT(a_sum_moves, sum_valid && sum_ready,
        m_axis_tvalid, "row sum handed on but no output transfer offered")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the vertex_transform 4x4 fixed-point stream pipeline.
`timescale 1ns / 100ps

module tb;
    import vt_pkg::*;

    // One expected output transfer: four components and the clamp flag.
    typedef struct packed {
        logic   clipped;
        coord_t w;
        coord_t z;
        coord_t y;
        coord_t x;
    } vertex_res_t;

    localparam coord_t C_MAX     = 32'sh7FFF_FFFF;
    localparam coord_t C_MIN     = 32'sh8000_0000;
    localparam coord_t C_ZERO    = 32'sd0;
    localparam coord_t C_LSB     = 32'sd1;
    localparam coord_t C_LSB_NEG = -32'sd1;
    localparam coord_t C_ONE     = coord_t'(FIX_ONE);
    localparam coord_t C_NEG_ONE = -coord_t'(FIX_ONE);

    // Cycles allowed after the last result, receiver hold length, run limit.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [95:0]          s_axis_tdata;    // point_x, point_y, point_z
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [127:0]         m_axis_tdata;    // out_x, out_y, out_z, out_w
    logic [0:0]           m_axis_tuser;    // clipped
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    // Expected vertices in transfer order and the testbench copy of the matrix.
    vertex_res_t      expected_vertices [$];
    logic [REG_W-1:0] matrix_regs [NUM_REGS];
    int               mismatch_count    = 0;
    int               sink_hold_cycles  = 0;
    bit               traffic_calm      = 1'b0;

    vertex_transform dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard stop in case the pipeline hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timeout at %0t", $time);
        $display("FAILURE");
        $finish;
    end

    // Matrix times (x, y, z, 1): each product is exact, shifted right
    // arithmetically (rounding towards minus infinity), summed wide, then clamped.
    function automatic vertex_res_t transform_point(input coord_t px, input coord_t py,
                                                    input coord_t pz);
        coord_t           pt [NUM_AXES];
        coord_t           comp [NUM_ROWS];
        coord_t           m;
        logic [REG_W-1:0] r;
        longint           acc;
        vertex_res_t      res;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        res.clipped = 1'b0;
        for (int row = 0; row < NUM_ROWS; row++)
        begin
            // The translation entry sits in the high half of the second register.
            r   = matrix_regs[row * 2 + 1];
            m   = r[REG_W-1:COORD_W];
            acc = longint'(m);
            for (int col = 0; col < NUM_AXES; col++)
            begin
                r = matrix_regs[row * 2 + col / 2];
                m = (col % 2 == 1) ? r[REG_W-1:COORD_W] : r[COORD_W-1:0];
                acc += (longint'(m) * longint'(pt[col])) >>> FRAC_BITS;
            end
            if (acc > longint'(C_MAX))
            begin
                comp[row]   = C_MAX;
                res.clipped = 1'b1;
            end
            else if (acc < longint'(C_MIN))
            begin
                comp[row]   = C_MIN;
                res.clipped = 1'b1;
            end
            else
                comp[row] = coord_t'(acc[COORD_W-1:0]);
        end
        res.x = comp[0];
        res.y = comp[1];
        res.z = comp[2];
        res.w = comp[3];
        return res;
    endfunction

    // Coordinates: full range, moderate magnitudes, extremes and values near one.
    function automatic coord_t rand_coord();
        coord_t v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3, 4, 5: v = coord_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       v = C_MAX;
                    1:       v = C_MIN;
                    2:       v = C_ZERO;
                    3:       v = C_LSB_NEG;
                    4:       v = C_ONE;
                    default: v = C_NEG_ONE;
                endcase
            end
            default: v = coord_t'($urandom_range(0, 32'h0000_FFFF)) + C_ONE - 32'sh0000_8000;
        endcase
        return v;
    endfunction

    // Matrix entries: mostly within +/-4.0 so that many results stay unclamped.
    function automatic coord_t rand_entry();
        coord_t v;
        case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: v = coord_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            5:             v = ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
            6:             v = $urandom;
            default:       v = C_ZERO;
        endcase
        return v;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker: every output transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        vertex_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %h clipped %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = expected_vertices.pop_front();
                check_field("out_x", want.x, m_axis_tdata[31:0]);
                check_field("out_y", want.y, m_axis_tdata[63:32]);
                check_field("out_z", want.z, m_axis_tdata[95:64]);
                check_field("out_w", want.w, m_axis_tdata[127:96]);
                check_field("clipped", {31'b0, want.clipped}, {31'b0, m_axis_tuser});
            end
        end
    end

    // Receiver: random stall bursts, long holds on request, none once traffic is calm.
    initial
    begin : output_sink
        int stall_left;
        bit bursty;
        stall_left = 0;
        bursty     = 1'b1;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                bursty = ~bursty;
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (!traffic_calm && bursty && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offer one point and wait for its transfer; tvalid stays high for a following point.
    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
        s_axis_tdata  <= {pz, py, px};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_vertices.push_back(transform_point(px, py, pz));
    endtask

    task automatic pause_source(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait until every outstanding vertex has been checked.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_vertices.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx < NUM_REGS)
            matrix_regs[idx] = val;
    endtask

    task automatic load_row(input logic [CFG_IDX_W-1:0] idx01, input logic [CFG_IDX_W-1:0] idx23,
                            input coord_t c0, input coord_t c1, input coord_t c2,
                            input coord_t c3);
        write_reg(idx01, {c1, c0});
        write_reg(idx23, {c3, c2});
    endtask

    task automatic load_random_matrix();
        load_row(REG_ROW0_COLS01, REG_ROW0_COLS23, rand_entry(), rand_entry(), rand_entry(),
                 rand_entry());
        load_row(REG_ROW1_COLS01, REG_ROW1_COLS23, rand_entry(), rand_entry(), rand_entry(),
                 rand_entry());
        load_row(REG_ROW2_COLS01, REG_ROW2_COLS23, rand_entry(), rand_entry(), rand_entry(),
                 rand_entry());
        // Half the time keep the bottom row affine.
        if ($urandom_range(0, 1) != 0)
            load_row(REG_ROW3_COLS01, REG_ROW3_COLS23, C_ZERO, C_ZERO, C_ZERO, C_ONE);
        else
            load_row(REG_ROW3_COLS01, REG_ROW3_COLS23, rand_entry(), rand_entry(),
                     rand_entry(), rand_entry());
    endtask

    // The identity matrix loaded by reset must pass points through unchanged.
    task automatic test_reset_matrix();
        send_point(C_ZERO, C_ZERO, C_ZERO);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_LSB_NEG, C_LSB, C_LSB_NEG);
        send_point(C_ONE, C_NEG_ONE, 32'sd12345);
        wait_for_results();
    endtask

    // Clamping in both directions, rounding of negative products, ignored indexes
    // and sums that land exactly on or just past the 32-bit limits.
    task automatic test_clamp_and_rounding();
        load_row(REG_ROW0_COLS01, REG_ROW0_COLS23, C_MAX, C_MAX, C_MAX, C_MAX);
        load_row(REG_ROW1_COLS01, REG_ROW1_COLS23, C_MIN, C_MIN, C_MIN, C_MIN);
        load_row(REG_ROW2_COLS01, REG_ROW2_COLS23, C_LSB_NEG, C_LSB_NEG, C_LSB_NEG, C_ZERO);
        load_row(REG_ROW3_COLS01, REG_ROW3_COLS23, C_ZERO, C_ZERO, C_ZERO, C_ONE);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_LSB, C_LSB, C_LSB);
        send_point(C_LSB_NEG, C_LSB_NEG, C_LSB_NEG);
        send_point(C_ZERO, C_ZERO, C_ZERO);
        send_point(C_MAX, C_MIN, C_ZERO);
        send_point(C_ONE, C_NEG_ONE, C_LSB);
        wait_for_results();

        // Writes past the last register must leave the matrix alone.
        for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
        send_point(rand_coord(), rand_coord(), rand_coord());
        send_point(C_LSB, C_ONE, C_NEG_ONE);
        send_point(rand_coord(), rand_coord(), rand_coord());
        wait_for_results();

        load_row(REG_ROW0_COLS01, REG_ROW0_COLS23, C_ONE, C_ZERO, C_ZERO, C_MAX);
        load_row(REG_ROW1_COLS01, REG_ROW1_COLS23, C_ONE, C_ZERO, C_ZERO, C_MIN);
        load_row(REG_ROW2_COLS01, REG_ROW2_COLS23, C_MIN, C_MIN, C_MIN, C_MIN);
        load_row(REG_ROW3_COLS01, REG_ROW3_COLS23, C_ZERO, C_ZERO, C_ZERO, C_ONE);
        send_point(C_ZERO, C_ZERO, C_ZERO);
        send_point(C_LSB, C_ZERO, C_ZERO);
        send_point(C_LSB_NEG, C_ZERO, C_ZERO);
        send_point(C_MIN, C_MIN, C_MIN);
        wait_for_results();
    endtask

    // Random matrices, each followed by random points with bursts of source gaps.
    task automatic test_random_matrices(input int phases, input int points);
        bit src_bursty;
        src_bursty = 1'b1;
        for (int ph = 0; ph < phases; ph++)
        begin
            wait_for_results();
            load_random_matrix();
            for (int i = 0; i < points; i++)
            begin
                if (i % 20 == 0)
                    src_bursty = ($urandom_range(0, 2) != 0);
                if (src_bursty && !traffic_calm && $urandom_range(0, 3) == 0)
                    pause_source($urandom_range(1, 11));
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
        end
        wait_for_results();
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its
    // input; the source then waits for every result before going on.
    task automatic test_output_hold();
        wait_for_results();
        load_random_matrix();
        sink_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        wait_for_results();
    endtask

    // Back-to-back transfers with neither side idling.
    task automatic test_steady_stream();
        traffic_calm = 1'b1;
        load_random_matrix();
        for (int i = 0; i < 80; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        wait_for_results();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;

        // Reset contents of the matrix: the identity.
        for (int i = 0; i < NUM_REGS; i++)
            matrix_regs[i] = '0;
        matrix_regs[REG_ROW0_COLS01] = {{COORD_W{1'b0}}, FIX_ONE};
        matrix_regs[REG_ROW1_COLS01] = {FIX_ONE, {COORD_W{1'b0}}};
        matrix_regs[REG_ROW2_COLS23] = {{COORD_W{1'b0}}, FIX_ONE};
        matrix_regs[REG_ROW3_COLS23] = {FIX_ONE, {COORD_W{1'b0}}};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix();
        test_clamp_and_rounding();
        test_random_matrices(7, 75);
        test_output_hold();
        test_steady_stream();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_vertices.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/vt_pkg.sv
src/vt_matrix.sv
src/vt_mult.sv
src/vt_rowsum.sv
src/vt_saturate.sv
src/vertex_transform.sv
tb/tb.sv
